### src/ckb_pkg.sv
`timescale 1ns / 1ps

package ckb_pkg;

  localparam int unsigned DestWidthDef  = 320;
  localparam int unsigned DestHeightDef = 240;

  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned EdgeW    = 10;
  localparam int unsigned PosW     = 11;
  localparam int unsigned OutXW    = 9;
  localparam int unsigned OutYW    = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_LEFT   = 3'd0,
    CFG_SRC_TOP    = 3'd1,
    CFG_SRC_RIGHT  = 3'd2,
    CFG_SRC_BOTTOM = 3'd3,
    CFG_DEST_POS_X = 3'd4,
    CFG_DEST_POS_Y = 3'd5,
    CFG_KEY_ENABLE = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [EdgeW-1:0]       src_left;
    logic [EdgeW-1:0]       src_top;
    logic [EdgeW-1:0]       src_right;
    logic [EdgeW-1:0]       src_bottom;
    logic signed [PosW-1:0] dest_pos_x;
    logic signed [PosW-1:0] dest_pos_y;
    logic                   key_enable;
  } cfg_t;

  typedef struct packed {
    logic [9:0] pix_x;
    logic [9:0] pix_y;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [OutXW-1:0] out_x;
    logic [OutYW-1:0] out_y;
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
  } pix_out_t;

endpackage

### src/ckb_cfg.sv
`timescale 1ns / 1ps

module ckb_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ckb_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ckb_pkg::CfgDataW-1:0]      cfg_data_i,
  output ckb_pkg::cfg_t                     cfg_o
);

  ckb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ckb_pkg::cfg_idx_e'(cfg_idx_i))
        ckb_pkg::CFG_SRC_LEFT:   cfg_d.src_left   = cfg_data_i[ckb_pkg::EdgeW-1:0];
        ckb_pkg::CFG_SRC_TOP:    cfg_d.src_top    = cfg_data_i[ckb_pkg::EdgeW-1:0];
        ckb_pkg::CFG_SRC_RIGHT:  cfg_d.src_right  = cfg_data_i[ckb_pkg::EdgeW-1:0];
        ckb_pkg::CFG_SRC_BOTTOM: cfg_d.src_bottom = cfg_data_i[ckb_pkg::EdgeW-1:0];
        ckb_pkg::CFG_DEST_POS_X: cfg_d.dest_pos_x = $signed(cfg_data_i[ckb_pkg::PosW-1:0]);
        ckb_pkg::CFG_DEST_POS_Y: cfg_d.dest_pos_y = $signed(cfg_data_i[ckb_pkg::PosW-1:0]);
        ckb_pkg::CFG_KEY_ENABLE: cfg_d.key_enable = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/ckb_axis.sv
`timescale 1ns / 1ps

// One axis of the clip test, two register stages deep. The near edge moves
// inward by the negative part of the destination position, and the far edge
// test checks the source coordinate against hi_i and the destination coordinate staying below the extent.
module ckb_axis #(
  parameter int unsigned EXTENT  = ckb_pkg::DestWidthDef,
  parameter int unsigned COORD_W = ckb_pkg::OutXW
) (
  input  logic                            clk_i,
  input  logic [ckb_pkg::EdgeW-1:0]       lo_i,
  input  logic [ckb_pkg::EdgeW-1:0]       hi_i,
  input  logic signed [ckb_pkg::PosW-1:0] pos_i,
  input  logic [9:0]                      pix_i,
  output logic                            inside_o,
  output logic [COORD_W-1:0]              coord_o
);

  localparam logic signed [13:0] ExtentS = 14'(EXTENT);

  logic [11:0]        lo_eff_d, lo_eff_q;
  logic [9:0]         base1_d, base1_q, base2_q;
  logic [9:0]         pix1_q;
  logic signed [12:0] off_d, off_q;
  logic               below_hi_d, below_hi_q;
  logic signed [13:0] dest;

  always_comb begin
    lo_eff_d   = {2'b00, lo_i} - (pos_i[10] ? {pos_i[10], pos_i} : 12'd0);
    base1_d    = pos_i[10] ? 10'd0 : pos_i[9:0];
    off_d      = $signed({3'b000, pix1_q}) - $signed({1'b0, lo_eff_q});
    below_hi_d = pix1_q < hi_i;
  end

  always_ff @(posedge clk_i) begin
    lo_eff_q   <= lo_eff_d;
    base1_q    <= base1_d;
    pix1_q     <= pix_i;
    off_q      <= off_d;
    base2_q    <= base1_q;
    below_hi_q <= below_hi_d;
  end

  always_comb begin
    dest     = $signed({4'b0000, base2_q}) + $signed({off_q[12], off_q});
    inside_o = !off_q[12] && below_hi_q && (dest < ExtentS);
    coord_o  = dest[COORD_W-1:0];
  end

endmodule

### src/clipped_colour_key_blit.sv
`timescale 1ns / 1ps

// Per-pixel stage of a 2D blitter with rectangle clipping and a colour key.
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is high
// (0 src_left, 1 src_top, 2 src_right, 3 src_bottom, 4 dest_pos_x,
// 5 dest_pos_y, 6 key_enable); other indexes are ignored. Write only while no
// pixel is in flight.
// Input: a source pixel word on pix_i is taken at each clock edge with
// start_i high and busy_o low. busy_o is always low, so one word per clock.
// Output: a word that lies inside the clipped rectangle and is not keyed
// appears on result_o once it has passed the clip registers and the output
// register, with out_strobe_o high for exactly one cycle. Other words give no
// output. The receiver cannot hold results off, and the pipeline never stalls.
// The pipeline has three register stages, the last of them the output register.
// Throughput is one pixel per clock because busy_o never rises.
// Reset clears the valid flags and configuration and empties the pipeline.
module clipped_colour_key_blit #(
  parameter int unsigned DEST_WIDTH  = ckb_pkg::DestWidthDef,
  parameter int unsigned DEST_HEIGHT = ckb_pkg::DestHeightDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  ckb_pkg::pix_in_t             pix_i,
  output logic                         out_strobe_o,
  output ckb_pkg::pix_out_t            result_o,
  input  logic                         cfg_we_i,
  input  logic [ckb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ckb_pkg::CfgDataW-1:0] cfg_data_i
);

  ckb_pkg::cfg_t     cfg;
  logic              v1_q, v2_q, out_v_q, out_v_d;
  logic              keyed1_q, keyed2_q;
  logic [23:0]       rgb1_q, rgb2_q;
  logic              in_x, in_y;
  logic [ckb_pkg::OutXW-1:0] coord_x;
  logic [ckb_pkg::OutYW-1:0] coord_y;
  ckb_pkg::pix_out_t out_q, out_d;

  ckb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ckb_axis #(.EXTENT(DEST_WIDTH), .COORD_W(ckb_pkg::OutXW)) u_axis_x (
    .clk_i    (clk_i),
    .lo_i     (cfg.src_left),
    .hi_i     (cfg.src_right),
    .pos_i    (cfg.dest_pos_x),
    .pix_i    (pix_i.pix_x),
    .inside_o (in_x),
    .coord_o  (coord_x)
  );

  ckb_axis #(.EXTENT(DEST_HEIGHT), .COORD_W(ckb_pkg::OutYW)) u_axis_y (
    .clk_i    (clk_i),
    .lo_i     (cfg.src_top),
    .hi_i     (cfg.src_bottom),
    .pos_i    (cfg.dest_pos_y),
    .pix_i    (pix_i.pix_y),
    .inside_o (in_y),
    .coord_o  (coord_y)
  );

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v1_q    <= start_i && !busy_o;
      v2_q    <= v1_q;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    keyed1_q <= cfg.key_enable && (pix_i.in_red == 8'd0) && (pix_i.in_green == 8'd0)
                && (pix_i.in_blue == 8'd0);
    keyed2_q <= keyed1_q;
    rgb1_q   <= {pix_i.in_red, pix_i.in_green, pix_i.in_blue};
    rgb2_q   <= rgb1_q;
    out_q    <= out_d;
  end

  always_comb begin
    out_v_d         = v2_q && in_x && in_y && !keyed2_q;
    out_d.out_x     = coord_x;
    out_d.out_y     = coord_y;
    out_d.out_red   = rgb2_q[23:16];
    out_d.out_green = rgb2_q[15:8];
    out_d.out_blue  = rgb2_q[7:0];
  end

  assign out_strobe_o = out_v_q;
  assign result_o     = out_q;

endmodule

### src/ckb_checker.sv
`timescale 1ns / 1ps

module ckb_checker #(
  parameter int unsigned DEST_WIDTH  = ckb_pkg::DestWidthDef,
  parameter int unsigned DEST_HEIGHT = ckb_pkg::DestHeightDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input ckb_pkg::pix_in_t             pix_i,
  input logic                         out_strobe_o,
  input ckb_pkg::pix_out_t            result_o,
  input logic                         cfg_we_i,
  input logic [ckb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [ckb_pkg::CfgDataW-1:0] cfg_data_i
);

  logic key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= 1'b0;
    end else if (cfg_we_i && (cfg_idx_i == ckb_pkg::CFG_KEY_ENABLE)) begin
      key_q <= cfg_data_i[0];
    end
  end

  // Every output word comes from a matching word taken at the input.
  a_word_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(start_i && !busy_o, 3))
    else $error("output word without a matching input word");

  a_colour_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> (result_o.out_red == $past(pix_i.in_red, 3))
                     && (result_o.out_green == $past(pix_i.in_green, 3))
                     && (result_o.out_blue == $past(pix_i.in_blue, 3)))
    else $error("output colour differs from input colour");

  a_key_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && key_q) |-> ((result_o.out_red != 8'd0)
                                 || (result_o.out_green != 8'd0)
                                 || (result_o.out_blue != 8'd0)))
    else $error("keyed black pixel was written");

  a_in_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> ((DEST_WIDTH > 512) || (32'(result_o.out_x) < DEST_WIDTH))
                     && ((DEST_HEIGHT > 256) || (32'(result_o.out_y) < DEST_HEIGHT)))
    else $error("output coordinate outside destination");

endmodule

bind clipped_colour_key_blit ckb_checker #(
  .DEST_WIDTH  (DEST_WIDTH),
  .DEST_HEIGHT (DEST_HEIGHT)
) u_ckb_checker (.*);
